// ===== rtl/core/dtq_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dtq_pkg - shared types and constants of the deadline timer queue
// words on both channels, table entry layout, sequencer states
// ---------------------------------------------------------------------------
package dtq_pkg;

   localparam int DEPTH_DEF   = 16;
   localparam int MAX_RESULTS = 16;
   localparam int TIME_W      = 32;
   localparam int HANDLE_W    = 16;
   localparam int DELAY_W     = 16;

   localparam logic       CMD_ADD  = 1'b0;
   localparam logic       CMD_TICK = 1'b1;

   localparam logic [1:0] KIND_ACCEPT = 2'd0;
   localparam logic [1:0] KIND_REJECT = 2'd1;
   localparam logic [1:0] KIND_FIRED  = 2'd2;

   typedef struct packed {
      logic                command;
      logic [HANDLE_W-1:0] handle;
      logic [DELAY_W-1:0]  delay;
   } req_type;

   typedef struct packed {
      logic [1:0]          kind;
      logic [HANDLE_W-1:0] fired_handle;
      logic                last;
   } rsp_type;

   typedef struct packed {
      logic [TIME_W-1:0]   deadline;
      logic [HANDLE_W-1:0] handle;
   } entry_type;

   typedef struct packed {
      logic later;
      logic expired;
   } cmp_flags_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_RD,
      ST_INS_CMP,
      ST_FIRE_RD,
      ST_FIRE_CMP,
      ST_FINISH
   } state_type;

endpackage

// ===== rtl/core/dtq_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dtq_ram - generic single write, single read ram
// one write port, one read port with registered read data
// ---------------------------------------------------------------------------
module dtq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/dtq_cmp.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dtq_cmp - shared wrap-safe time comparator
// one 32-bit subtractor used for sort order and for expiry
// ---------------------------------------------------------------------------
module dtq_cmp (
   input  logic [dtq_pkg::TIME_W-1:0] op_a,
   input  logic [dtq_pkg::TIME_W-1:0] op_b,
   output dtq_pkg::cmp_flags_type     flags
);
   import dtq_pkg::*;

   logic [TIME_W-1:0] diff;

   assign diff = op_a - op_b;

   // a after b: nonzero difference in the forward half of the wrap
   assign flags.later   = (diff != '0) && !diff[TIME_W-1];
   // a at or after b
   assign flags.expired = !diff[TIME_W-1];

endmodule

// ===== rtl/core/deadline_timer_queue_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// deadline_timer_queue_top - sorted table of pending timers
// add and tick words in, accept, reject and fired words out
// ---------------------------------------------------------------------------
// a tick or a rejected add walks the front of the table for fired timers, then closes;
// an accepted add first shifts each entry with a later deadline, then places the new one
// the walk is bounded by DEPTH and MAX_RESULTS and is set by the one ram read
// port walked by the sequencer; a stalled result adds its stall; one word at a time
// reset: synchronous, clears the clock, count, head, sequencer and output valid;
// table contents need no clearing since only live entries are read
// ---------------------------------------------------------------------------
module deadline_timer_queue_top #(
   parameter int DEPTH = dtq_pkg::DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  dtq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output dtq_pkg::rsp_type rsp_data
);
   import dtq_pkg::*;

   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int PW = CW + 1;
   localparam int NW = $clog2(MAX_RESULTS + 1);
   localparam int EW = $bits(entry_type);

   // sequencer and control state
   state_type         state_ff, state_in;
   logic [TIME_W-1:0] time_ff, time_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [IW-1:0]     head_ff, head_in;
   logic [CW-1:0]     pos_ff, pos_in;
   logic [NW-1:0]     n_ff, n_in;
   logic              hold_valid_ff, hold_valid_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic [TIME_W-1:0] new_dl_ff, new_dl_in;
   logic [1:0]        hold_kind_ff, hold_kind_in;
   logic [HANDLE_W-1:0] hold_handle_ff, hold_handle_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   // table ram and shared comparator
   logic          wr_en;
   logic [IW-1:0] wr_addr;
   entry_type     wr_entry;
   logic [IW-1:0] rd_addr;
   entry_type     rd_entry;
   logic [EW-1:0] rd_raw;
   logic [TIME_W-1:0] cmp_a, cmp_b;
   cmp_flags_type cmp_flags;
   logic          out_free;

   // logical table position to ram address, ring starting at head
   function automatic logic [IW-1:0] phys(input logic [IW-1:0] head,
                                          input logic [CW-1:0] pos);
      logic [PW-1:0] sum;
      sum = PW'(head) + PW'(pos);
      if (sum >= PW'(DEPTH)) begin
         sum = sum - PW'(DEPTH);
      end
      return sum[IW-1:0];
   endfunction

   dtq_ram #(
      .WIDTH (EW),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   assign rd_entry = entry_type'(rd_raw);

   dtq_cmp u_cmp (
      .op_a  (cmp_a),
      .op_b  (cmp_b),
      .flags (cmp_flags)
   );

   // output register frees when empty or being taken this cycle
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         time_ff       <= '0;
         count_ff      <= '0;
         head_ff       <= '0;
         pos_ff        <= '0;
         n_ff          <= '0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         time_ff       <= time_in;
         count_ff      <= count_in;
         head_ff       <= head_in;
         pos_ff        <= pos_in;
         n_ff          <= n_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      new_dl_ff      <= new_dl_in;
      hold_kind_ff   <= hold_kind_in;
      hold_handle_ff <= hold_handle_in;
      rsp_data_ff    <= rsp_data_in;
   end

   always_comb begin
      state_in       = state_ff;
      time_in        = time_ff;
      count_in       = count_ff;
      head_in        = head_ff;
      pos_in         = pos_ff;
      n_in           = n_ff;
      hold_valid_in  = hold_valid_ff;
      hold_kind_in   = hold_kind_ff;
      hold_handle_in = hold_handle_ff;
      new_dl_in      = new_dl_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;

      wr_en    = 1'b0;
      wr_addr  = phys(head_ff, pos_ff);
      wr_entry = '{deadline: new_dl_ff, handle: hold_handle_ff};
      // the front entry is read unless the insert walk needs another one
      rd_addr  = head_ff;

      // shared comparator: sort order while inserting, expiry otherwise
      if (state_ff == ST_INS_CMP) begin
         cmp_a = rd_entry.deadline;
         cmp_b = new_dl_ff;
      end else begin
         cmp_a = time_ff;
         cmp_b = rd_entry.deadline;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_data.command == CMD_TICK) begin
                  // tick: advance time, go straight to the expiry walk
                  time_in       = time_ff + TIME_W'(1);
                  n_in          = '0;
                  hold_valid_in = 1'b0;
                  state_in      = ST_FIRE_RD;
               end else begin
                  // add status word is held until we know whether it is last
                  n_in           = NW'(1);
                  hold_valid_in  = 1'b1;
                  hold_handle_in = req_data.handle;
                  if (count_ff == CW'(DEPTH)) begin
                     hold_kind_in = KIND_REJECT;
                     state_in     = ST_FIRE_RD;
                  end else begin
                     hold_kind_in = KIND_ACCEPT;
                     new_dl_in    = time_ff + TIME_W'(req_data.delay);
                     pos_in       = count_ff;
                     state_in     = ST_INS_RD;
                  end
               end
            end
         end
         ST_INS_RD: begin
            if (pos_ff == '0) begin
               // reached the front: new entry goes in slot zero
               wr_en    = 1'b1;
               count_in = count_ff + CW'(1);
               state_in = ST_FIRE_RD;
            end else begin
               rd_addr  = phys(head_ff, pos_ff - CW'(1));
               state_in = ST_INS_CMP;
            end
         end
         ST_INS_CMP: begin
            wr_en = 1'b1;
            if (cmp_flags.later) begin
               // shift the later entry one place towards the tail
               wr_entry = rd_entry;
               pos_in   = pos_ff - CW'(1);
               state_in = ST_INS_RD;
            end else begin
               // equal or earlier deadline ahead: insert behind it
               count_in = count_ff + CW'(1);
               state_in = ST_FIRE_RD;
            end
         end
         ST_FIRE_RD: begin
            if (count_ff != '0 && n_ff < NW'(MAX_RESULTS)) begin
               state_in = ST_FIRE_CMP;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_FIRE_CMP: begin
            if (!cmp_flags.expired) begin
               state_in = ST_FINISH;
            end else if (!hold_valid_ff || out_free) begin
               // push the held word out as not last, hold the fired one
               if (hold_valid_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '{kind: hold_kind_ff, fired_handle: hold_handle_ff,
                                   last: 1'b0};
               end
               hold_valid_in  = 1'b1;
               hold_kind_in   = KIND_FIRED;
               hold_handle_in = rd_entry.handle;
               head_in        = (head_ff == IW'(DEPTH - 1)) ? '0 : head_ff + IW'(1);
               count_in       = count_ff - CW'(1);
               n_in           = n_ff + NW'(1);
               state_in       = ST_FIRE_RD;
            end
         end
         ST_FINISH: begin
            if (!hold_valid_ff) begin
               // idle tick, nothing to report
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = '{kind: hold_kind_ff, fired_handle: hold_handle_ff,
                                 last: 1'b1};
               hold_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/core/dtq_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dtq_checker - port level checks of the deadline timer queue
// watches the two channels and is bound to the top level
// ---------------------------------------------------------------------------
module dtq_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input dtq_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input dtq_pkg::rsp_type rsp_data
);
   import dtq_pkg::*;

   // a stalled result word stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");

   // a waiting input word stays put
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_data))
      else $error("input word changed while stalled");

   // one word in work at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken again right after an accept");

   // more results of the same word follow, so no new word may enter
   a_not_last_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_data.last |-> req_stall)
      else $error("input open while results of a word are still due");

   // reset empties the output register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind deadline_timer_queue_top dtq_checker u_dtq_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
